// File: design/pst_pkg.sv
// Shared types and constants of the priority sum tree sampler.
package pst_pkg;

    localparam int SUM_W  = 42;
    localparam int MIN_W  = 17;
    localparam int PRIO_W = 32;
    localparam int SLOT_W = 10;
    localparam int CAP_W  = 11;
    localparam int OP_W   = 2;

    localparam logic [MIN_W-1:0]  MIN_NONE  = 17'd65536;
    localparam logic [PRIO_W-1:0] MAX_RESET = 32'h0001_0000;
    localparam logic [CAP_W-1:0]  CAP_RESET = 11'd1024;

    // Operation codes carried in the input tuser field.
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF,
        S_UP,
        S_SROOT,
        S_SDESC,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic leaf;
        logic up;
        logic sroot;
        logic sdesc;
        logic done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic walk_last;
        logic desc_last;
        logic fill_empty;
        logic out_free;
    } t_stat;

endpackage

// File: design/priority_sum_tree_sampler_top.sv
// Top level of the priority sum tree sampler: controller plus datapath.
// Add and update write the leaf, then recompute one tree level per node memory access up to
// the root; sample sets up at the root, then descends one tree level per node memory access.
// The result word is then registered, and the next word is accepted after that; an empty
// sample or unused opcode goes straight to its result word; a waiting word stalls.
// Reset runs a clearing sweep over all 2*LEAVES node entries; configuration writes are taken throughout.
module priority_sum_tree_sampler_top
    import pst_pkg::*;
#(
    parameter int LEAVES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [10:0]   i_cfg_wdata,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // slot_index [9:0], priority_req [41:10], target [83:42], zero [87:84]
    input  logic [87:0]   i_s_axis_tdata,
    // opcode [1:0]
    input  logic [1:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // chosen_slot [9:0], total_sum [51:10], min_integer [68:52], max_seen [100:69],
    // zero [103:101]
    output logic [103:0]  o_m_axis_tdata,
    // empty_res [0]
    output logic          o_m_axis_tuser
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [SLOT_W-1:0] w_chosen;
    logic [SUM_W-1:0]  w_total;
    logic [MIN_W-1:0]  w_min;
    logic [PRIO_W-1:0] w_max;

    // Sequencer.
    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_opcode   (i_s_axis_tuser),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Tree storage and arithmetic.
    pst_dpath #(
        .LEAVES (LEAVES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (i_s_axis_tuser),
        .i_slot      (i_s_axis_tdata[9:0]),
        .i_prio      (i_s_axis_tdata[41:10]),
        .i_target    (i_s_axis_tdata[83:42]),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_chosen    (w_chosen),
        .o_empty     (o_m_axis_tuser),
        .o_total     (w_total),
        .o_min       (w_min),
        .o_max       (w_max)
    );

    // Output word packing.
    assign o_m_axis_tdata = {3'b000, w_max, w_min, w_total, w_chosen};

endmodule

// File: design/pst_ctrl.sv
// Controller state machine of the priority sum tree sampler.
module pst_ctrl
    import pst_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_opcode,
    input  t_stat           i_stat,
    output logic            o_in_ready,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts the memory clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_ADD:    n_state = S_LEAF;
                        OP_UPDATE: n_state = S_LEAF;
                        OP_SAMPLE: n_state = i_stat.fill_empty ? S_DONE : S_SROOT;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_LEAF:  n_state = S_UP;
            S_UP: begin
                if (i_stat.walk_last) n_state = S_DONE;
            end
            S_SROOT: n_state = S_SDESC;
            S_SDESC: begin
                if (i_stat.desc_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_LEAF:  o_cmd.leaf  = 1'b1;
            S_UP:    o_cmd.up    = 1'b1;
            S_SROOT: o_cmd.sroot = 1'b1;
            S_SDESC: o_cmd.sdesc = 1'b1;
            S_DONE:  o_cmd.done  = i_stat.out_free;
            default: o_cmd       = '0;
        endcase
    end

endmodule

// File: design/pst_dpath.sv
// Datapath of the priority sum tree sampler: node memories, tree walk and descent.
module pst_dpath
    import pst_pkg::*;
#(
    parameter int LEAVES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [PRIO_W-1:0] i_prio,
    input  logic [SUM_W-1:0]  i_target,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SLOT_W-1:0] o_chosen,
    output logic              o_empty,
    output logic [SUM_W-1:0]  o_total,
    output logic [MIN_W-1:0]  o_min,
    output logic [PRIO_W-1:0] o_max
);

    localparam int LW = $clog2(LEAVES);
    localparam int NW = LW + 1;

    // Node memories, indexed by heap node number.
    logic [SUM_W-1:0] r_sum_mem [2*LEAVES];
    logic [MIN_W-1:0] r_min_mem [2*LEAVES];
    logic [SUM_W-1:0] r_rd_sum;
    logic [MIN_W-1:0] r_rd_min;

    // Latched item.
    logic [OP_W-1:0]   r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [PRIO_W-1:0] r_prio;
    logic [SUM_W-1:0]  r_target;

    // Architectural state.
    logic [CAP_W-1:0]  r_cap;
    logic [LW-1:0]     r_wp;
    logic [NW-1:0]     r_fill;
    logic [PRIO_W-1:0] r_max;
    logic [SUM_W-1:0]  r_root_sum;
    logic [MIN_W-1:0]  r_root_min;
    logic [NW-1:0]     r_clr_cnt;

    // Walk state.
    logic [NW-1:0]     r_node;
    logic [SUM_W-1:0]  r_cur_sum;
    logic [MIN_W-1:0]  r_cur_min;
    logic [SUM_W-1:0]  r_v;
    logic [NW-1:0]     r_rem;
    logic [NW-1:0]     r_div;
    logic [LW-1:0]     r_chosen;
    logic              r_empty;

    // Result register.
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_o_chosen;
    logic              r_o_empty;
    logic [SUM_W-1:0]  r_o_total;
    logic [MIN_W-1:0]  r_o_min;
    logic [PRIO_W-1:0] r_o_max;

    logic [31:0]       w_cap32;
    logic [31:0]       w_eff32;
    logic [NW-1:0]     w_eff_cap;
    logic [31:0]       w_slot32;
    logic [LW-1:0]     w_slot_lw;
    logic [NW-1:0]     w_leaf_node;
    logic [NW-1:0]     w_parent;
    logic [SUM_W:0]    w_psum_wide;
    logic [SUM_W-1:0]  w_psum;
    logic [MIN_W-1:0]  w_pmin;
    logic [PRIO_W-1:0] w_leaf_prio;
    logic              w_go_left;
    logic [NW-1:0]     n_node;
    logic [SUM_W-1:0]  n_v;
    logic [LW-1:0]     w_leaf;
    logic [NW-1:0]     w_fill_m1;
    logic [LW-1:0]     w_pick;
    logic [NW-1:0]     w_dividend;
    logic [NW-1:0]     w_fill_inc;
    logic [31:0]       w_chosen32;
    logic              w_we;
    logic [NW-1:0]     w_waddr;
    logic [SUM_W-1:0]  w_wsum;
    logic [MIN_W-1:0]  w_wmin;
    logic [NW-1:0]     w_raddr;

    // One restoring step of the remainder by the ring capacity.
    function automatic logic [NW-1:0] rem_step(input logic [NW-1:0] r, input logic b,
                                                input logic [NW-1:0] c);
        logic [NW:0] t;
        t = {r, b};
        if (t >= {1'b0, c}) t = t - {1'b0, c};
        return t[NW-1:0];
    endfunction

    // Effective capacity: zero acts as one, above the leaf count as the leaf count.
    assign w_cap32   = {21'b0, r_cap};
    assign w_eff32   = (r_cap == '0) ? 32'd1 :
                       ((w_cap32 > 32'(LEAVES)) ? 32'(LEAVES) : w_cap32);
    assign w_eff_cap = w_eff32[NW-1:0];

    // Leaf addressing for add and update.
    assign w_slot32    = 32'(r_slot);
    assign w_slot_lw   = (r_op == OP_ADD) ? r_wp : w_slot32[LW-1:0];
    assign w_leaf_node = {1'b1, w_slot_lw};
    assign w_leaf_prio = (r_op == OP_ADD) ? r_max : r_prio;

    // Parent recompute: saturating sum and minimum of the two children.
    assign w_parent    = r_node >> 1;
    assign w_psum_wide = {1'b0, r_cur_sum} + {1'b0, r_rd_sum};
    assign w_psum      = w_psum_wide[SUM_W] ? {SUM_W{1'b1}} : w_psum_wide[SUM_W-1:0];
    assign w_pmin      = (r_cur_min < r_rd_min) ? r_cur_min : r_rd_min;

    // Descent step: compare the remaining target with the left child sum.
    assign w_go_left = (r_rd_sum >= r_v);
    assign n_node    = {r_node[NW-2:0], ~w_go_left};
    assign n_v       = w_go_left ? r_v : (r_v - r_rd_sum);
    assign w_leaf    = n_node[LW-1:0];
    assign w_fill_m1 = r_fill - NW'(1);
    assign w_pick    = ({1'b0, w_leaf} < w_fill_m1) ? w_leaf : w_fill_m1[LW-1:0];

    assign w_dividend = {1'b0, r_wp} + NW'(1);
    assign w_fill_inc = r_fill + NW'(1);

    // Memory port selection.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_cnt;
        w_wsum  = '0;
        w_wmin  = MIN_NONE;
        w_raddr = NW'(2);
        if (i_cmd.clear) begin
            w_we = 1'b1;
        end else if (i_cmd.leaf) begin
            w_we    = 1'b1;
            w_waddr = w_leaf_node;
            w_wsum  = SUM_W'(w_leaf_prio);
            w_wmin  = MIN_W'(w_leaf_prio >> 16);
            w_raddr = w_leaf_node ^ NW'(1);
        end else if (i_cmd.up) begin
            w_we    = 1'b1;
            w_waddr = w_parent;
            w_wsum  = w_psum;
            w_wmin  = w_pmin;
            w_raddr = w_parent ^ NW'(1);
        end else if (i_cmd.sdesc) begin
            w_raddr = {n_node[NW-2:0], 1'b0};
        end
    end

    // Node memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_sum_mem[w_waddr] <= w_wsum;
            r_min_mem[w_waddr] <= w_wmin;
        end
        r_rd_sum <= r_sum_mem[w_raddr];
        r_rd_min <= r_min_mem[w_raddr];
    end

    // Item latch and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_opcode;
            r_slot   <= i_slot;
            r_prio   <= i_prio;
            r_target <= i_target;
            r_chosen <= '0;
            r_empty  <= (i_opcode == OP_SAMPLE) && (r_fill == '0);
        end
        if (i_cmd.leaf) begin
            r_node    <= w_leaf_node;
            r_cur_sum <= SUM_W'(w_leaf_prio);
            r_cur_min <= MIN_W'(w_leaf_prio >> 16);
            r_chosen  <= w_slot_lw;
            r_rem     <= rem_step('0, w_dividend[NW-1], w_eff_cap);
            r_div     <= w_dividend << 1;
        end
        if (i_cmd.up) begin
            r_node    <= w_parent;
            r_cur_sum <= w_psum;
            r_cur_min <= w_pmin;
            r_rem     <= rem_step(r_rem, r_div[NW-1], w_eff_cap);
            r_div     <= r_div << 1;
        end
        if (i_cmd.sroot) begin
            r_node <= NW'(1);
            r_v    <= r_target;
        end
        if (i_cmd.sdesc) begin
            r_node <= n_node;
            r_v    <= n_v;
            if (n_node[NW-1]) r_chosen <= w_pick;
        end
    end

    // Architectural state and the clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_wp       <= '0;
            r_fill     <= '0;
            r_max      <= MAX_RESET;
            r_root_sum <= '0;
            r_root_min <= MIN_NONE;
            r_clr_cnt  <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (i_cmd.clear) r_clr_cnt <= r_clr_cnt + NW'(1);
            if (w_we && (w_waddr == NW'(1))) begin
                r_root_sum <= w_wsum;
                r_root_min <= w_wmin;
            end
            if (i_cmd.leaf && (r_op == OP_UPDATE) && (r_prio > r_max)) r_max <= r_prio;
            if (i_cmd.done && (r_op == OP_ADD)) begin
                r_wp   <= r_rem[LW-1:0];
                r_fill <= (w_fill_inc < w_eff_cap) ? w_fill_inc : w_eff_cap;
            end
        end
    end

    // Result register; the next item may start while a word waits here.
    assign w_chosen32 = 32'(r_chosen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_o_chosen <= w_chosen32[SLOT_W-1:0];
            r_o_empty  <= r_empty;
            r_o_total  <= r_root_sum;
            r_o_min    <= r_root_min;
            r_o_max    <= r_max;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_chosen = r_o_chosen;
    assign o_empty  = r_o_empty;
    assign o_total  = r_o_total;
    assign o_min    = r_o_min;
    assign o_max    = r_o_max;

    // Status to the controller.
    assign o_stat.clear_last = (r_clr_cnt == {NW{1'b1}});
    assign o_stat.walk_last  = (w_parent == NW'(1));
    assign o_stat.desc_last  = n_node[NW-1];
    assign o_stat.fill_empty = (r_fill == '0);
    assign o_stat.out_free   = !r_out_valid || i_ready;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NW'(LEAVES))
        else $error("fill count above leaf count");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.done && (r_op == OP_ADD)) |-> (r_rem < w_eff_cap))
        else $error("write pointer remainder not below capacity");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.done |=> r_out_valid)
        else $error("result word not presented after completion");
    a_rise_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.done))
        else $error("result word appeared without a completed operation");
`endif

endmodule

// File: dv/tb_priority_sum_tree_sampler_top.sv
// Self-checking testbench for the priority sum tree sampler top level.
module tb_priority_sum_tree_sampler_top;
    import pst_pkg::*;

    localparam int NLEAF = 1024;
    localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
        logic [SUM_W-1:0]  tgt;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              empty;
        logic [SUM_W-1:0]  total;
        logic [MIN_W-1:0]  min_int;
        logic [PRIO_W-1:0] max_prio;
    } t_rsp;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [10:0]  i_cfg_wdata = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [87:0]  i_s_axis_tdata = '0;
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [103:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;

    priority_sum_tree_sampler_top #(.LEAVES(NLEAF)) u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: the two trees, ring pointer, fill and running maximum.
    logic [SUM_W-1:0]  tree_sum [2*NLEAF];
    logic [MIN_W-1:0]  tree_min [2*NLEAF];
    logic [SLOT_W-1:0] wr_ptr;
    logic [CAP_W-1:0]  fill;
    logic [PRIO_W-1:0] top_prio;
    logic [CAP_W-1:0]  cap_reg;

    t_req pending_words[$];
    t_rsp expected_rsps[$];
    int   err_count = 0;
    bit   driver_hold = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    function automatic void put_leaf(input int slot, input logic [PRIO_W-1:0] p);
        int n;
        logic [SUM_W:0] s;
        n = slot + NLEAF;
        tree_sum[n] = SUM_W'(p);
        tree_min[n] = MIN_W'(p >> 16);
        while (n > 1) begin
            n = n >> 1;
            s = tree_sum[2*n] + tree_sum[2*n+1];
            tree_sum[n] = s > SUM_SAT ? SUM_SAT : s[SUM_W-1:0];
            tree_min[n] = tree_min[2*n] < tree_min[2*n+1] ? tree_min[2*n] : tree_min[2*n+1];
        end
    endfunction

    // Work out the one response word that a request causes.
    function automatic t_rsp predict_sample_tree(input t_req r);
        t_rsp o;
        int cap, n;
        logic [SUM_W-1:0] v;
        cap = cap_reg == 0 ? 1 : (cap_reg > NLEAF ? NLEAF : int'(cap_reg));
        o = '0;
        case (r.op)
            OP_ADD: begin
                o.slot = wr_ptr;
                put_leaf(wr_ptr, top_prio);
                wr_ptr = SLOT_W'((int'(wr_ptr) + 1) % cap);
                fill = int'(fill) + 1 < cap ? fill + 1'b1 : CAP_W'(cap);
            end
            OP_UPDATE: begin
                o.slot = r.slot;
                put_leaf(r.slot, r.prio);
                if (r.prio > top_prio) top_prio = r.prio;
            end
            OP_SAMPLE: begin
                if (fill == 0) begin
                    o.empty = 1'b1;
                end else begin
                    n = 1;
                    v = r.tgt;
                    while (n < NLEAF) begin
                        if (tree_sum[2*n] >= v) n = 2*n;
                        else begin
                            v = v - tree_sum[2*n];
                            n = 2*n + 1;
                        end
                    end
                    n = n - NLEAF;
                    o.slot = n < int'(fill) - 1 ? SLOT_W'(n) : SLOT_W'(fill - 1'b1);
                end
            end
            default: ;
        endcase
        o.total = tree_sum[1];
        o.min_int = tree_min[1];
        o.max_prio = top_prio;
        return o;
    endfunction

    function automatic int gap_len();
        return $urandom_range(0, 19) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Appends one request word to the sender queue.
    function automatic void queue_word(input t_req r);
        pending_words = {pending_words, r};
    endfunction

    // Driver: presents queued request words with random gaps.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            void'(pending_words.pop_front());
            expected_rsps = {expected_rsps, predict_sample_tree(t_req'({i_s_axis_tuser,
                i_s_axis_tdata[9:0], i_s_axis_tdata[41:10], i_s_axis_tdata[83:42]}))};
            send_gap = gap_len();
        end
        if ((i_s_axis_tvalid && !o_s_axis_tready) ||
            (send_gap == 0 && !driver_hold && pending_words.size() > 0 &&
             !(i_s_axis_tvalid && o_s_axis_tready && pending_words.size() == 0))) begin
            if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= pending_words[0].op;
                i_s_axis_tdata  <= {4'b0, pending_words[0].tgt, pending_words[0].prio,
                                    pending_words[0].slot};
            end
        end else begin
            i_s_axis_tvalid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
        end
    end

    // Monitor: checks each response word against the oldest prediction.
    int stall_len = 0;
    always @(posedge i_clk) begin
        t_rsp got, want;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_rsp'({o_m_axis_tdata[9:0], o_m_axis_tuser, o_m_axis_tdata[51:10],
                          o_m_axis_tdata[68:52], o_m_axis_tdata[100:69]});
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected word", 64'(got.slot), 0);
            end else begin
                want = expected_rsps.pop_front();
                if (got.slot != want.slot) report_mismatch("chosen_slot", got.slot, want.slot);
                if (got.empty != want.empty) report_mismatch("empty_res", got.empty, want.empty);
                if (got.total != want.total) report_mismatch("total_sum", got.total, want.total);
                if (got.min_int != want.min_int)
                    report_mismatch("min_integer", got.min_int, want.min_int);
                if (got.max_prio != want.max_prio)
                    report_mismatch("max_seen", got.max_prio, want.max_prio);
            end
        end
        if (stall_len > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_len <= stall_len - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_len <= gap_len();
        end
    end

    function automatic t_req mk(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] s,
                                input logic [PRIO_W-1:0] p, input logic [SUM_W-1:0] t);
        t_req r;
        r.op = op; r.slot = s; r.prio = p; r.tgt = t;
        return r;
    endfunction

    function automatic logic [PRIO_W-1:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 32'h0004_0000);
            1: return $urandom;
            2: return $urandom_range(0, 255);
            default: return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] rand_target();
        logic [SUM_W-1:0] t;
        t = SUM_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: return t;
            1: return tree_sum[1] == 0 ? t : t % (tree_sum[1] + 1);
            2: return SUM_W'($urandom_range(0, 32'h0010_0000));
            default: return tree_sum[1] + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_s_axis_tvalid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [10:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        cap_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int k;
        logic [OP_W-1:0] op;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = OP_ADD;
                4, 5: op = OP_UPDATE;
                9: op = $urandom_range(0, 30) == 0 ? OP_UNUSED : OP_SAMPLE;
                default: op = OP_SAMPLE;
            endcase
            queue_word(mk(op, SLOT_W'($urandom), rand_prio(), rand_target()));
            // Targets are drawn against the current tree, so keep the queue short.
            while (pending_words.size() > 2) @(posedge i_clk);
        end
    endtask

    initial begin
        for (int i = 0; i < 2*NLEAF; i++) begin
            tree_sum[i] = '0;
            tree_min[i] = MIN_NONE;
        end
        wr_ptr = '0;
        fill = '0;
        top_prio = MAX_RESET;
        cap_reg = CAP_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty sample, unused opcode, extremes of every field.
        write_capacity(11'd4);
        queue_word(mk(OP_SAMPLE, '0, '0, '0));
        queue_word(mk(OP_UNUSED, '1, '1, '1));
        queue_word(mk(OP_ADD, '1, '1, '1));
        queue_word(mk(OP_UPDATE, 10'd1023, 32'hFFFF_FFFF, '0));
        queue_word(mk(OP_UPDATE, 10'd0, 32'h0, '0));
        queue_word(mk(OP_UPDATE, 10'd512, 32'hFFFF_FFFF, '0));
        queue_word(mk(OP_SAMPLE, '0, '0, '0));
        queue_word(mk(OP_SAMPLE, '0, '0, '1));
        while (pending_words.size() > 0) @(posedge i_clk);
        // Hold the sender with words queued until everything is back.
        driver_hold = 1'b1;
        for (int i = 0; i < 6; i++) queue_word(mk(OP_ADD, '0, '0, '0));
        queue_word(mk(OP_SAMPLE, '0, '0, 42'h1_0000_0000));
        queue_word(mk(OP_SAMPLE, '0, '0, 42'h1));
        while (expected_rsps.size() > 0) @(posedge i_clk);
        driver_hold = 1'b0;
        wait_drained();

        // Capacity zero behaves as one; then lowered below pointer and fill.
        write_capacity(11'd0);
        random_phase(60);
        wait_drained();
        write_capacity(11'd2047);
        random_phase(300);
        wait_drained();
        write_capacity(11'd1024);
        random_phase(500);
        wait_drained();
        write_capacity(11'd3);
        random_phase(300);
        wait_drained();
        write_capacity(11'd1);
        random_phase(80);
        wait_drained();
        write_capacity(11'd37);
        random_phase(300);
        wait_drained();

        if (err_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
